// File: sv/bsf_pkg.sv
// shared types, constants and crc function of the byte stuffing framer
`default_nettype none
package bsf_pkg;

	localparam logic [7:0] FLAG_BYTE        = 8'h24;
	localparam logic [7:0] ESC_BYTE         = 8'h2F;
	localparam logic [7:0] CRC_POLY_RESET   = 8'h07;
	localparam int         SEQ_BITS_DEFAULT = 8;
	localparam int         NUM_SLOTS        = 5;

	// output slots of one item, in the order they go out
	typedef enum logic [2:0] {
		SLOT_OPEN,
		SLOT_ESC,
		SLOT_DATA,
		SLOT_CLOSE,
		SLOT_TRAIL
	} slot_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
		logic [7:0] seq_num;
	} item_t;

	// msb first, no reflection, no final xor
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ((c << 1) ^ poly) : (c << 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// File: sv/bsf_in_if.sv
// input channel: raw payload bytes with last mark and sequence number
`default_nettype none
interface bsf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;
	logic [7:0] seq_num;

	modport source (output valid, output data_byte, output frame_end, output seq_num,
		input ready);
	modport sink (input valid, input data_byte, input frame_end, input seq_num,
		output ready);
endinterface
`default_nettype wire

// File: sv/bsf_out_if.sv
// output channel: stuffed frame bytes and crc trailer
`default_nettype none
interface bsf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       is_trailer;
	logic [7:0] out_seq;
	logic       run_last;

	modport source (output valid, output out_byte, output is_trailer, output out_seq,
		output run_last, input ready);
	modport sink (input valid, input out_byte, input is_trailer, input out_seq,
		input run_last, output ready);
endinterface
`default_nettype wire

// File: sv/bsf_in_stage.sv
// input register holding the item being expanded
`default_nettype none
module bsf_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	bsf_in_if.sink             in_ch,
	input  wire logic          item_done,
	output bsf_pkg::item_t     item,
	output logic               item_valid
);

	logic           v_s1;
	bsf_pkg::item_t item_s1;
	logic           take;

	// free slot, or the held item leaves this cycle
	assign in_ch.ready = !v_s1 || item_done;
	assign take        = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (take) begin
			v_s1 <= 1'b1;
		end else if (item_done) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.data_byte <= in_ch.data_byte;
			item_s1.frame_end <= in_ch.frame_end;
			item_s1.seq_num   <= in_ch.seq_num;
		end
	end

	assign item       = item_s1;
	assign item_valid = v_s1;

endmodule
`default_nettype wire

// File: sv/bsf_emit.sv
// slot sequencer, crc accumulator and output register
`default_nettype none
module bsf_emit #(
	parameter int SEQ_BITS = bsf_pkg::SEQ_BITS_DEFAULT
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    crc_poly,
	input  wire bsf_pkg::item_t item,
	input  wire logic          item_valid,
	output logic               item_done,
	bsf_out_if.source          out_ch
);

	localparam int SeqW = (SEQ_BITS < 8) ? SEQ_BITS : 8;
	localparam int NS   = bsf_pkg::NUM_SLOTS;

	logic            in_frame_q;
	logic [7:0]      crc_q;
	logic [SeqW-1:0] frame_seq_q;
	logic [NS-1:0]   done_q;

	logic [NS-1:0]   need;
	logic [NS-1:0]   pending;
	logic [NS-1:0]   cur_bit;
	bsf_pkg::slot_t  cur;
	logic            is_last;
	logic            special;
	logic            fire;
	logic            out_free;
	logic [7:0]      byte_nx;
	logic [SeqW-1:0] seq_nx;
	logic [7:0]      crc_base;

	logic            out_v_q;
	logic [7:0]      out_byte_q;
	logic            is_trailer_q;
	logic [7:0]      out_seq_q;
	logic            run_last_q;

	assign special = (item.data_byte == bsf_pkg::FLAG_BYTE) ||
		(item.data_byte == bsf_pkg::ESC_BYTE);

	always_comb begin
		need                       = '0;
		need[bsf_pkg::SLOT_OPEN]   = !in_frame_q;
		need[bsf_pkg::SLOT_ESC]    = special;
		need[bsf_pkg::SLOT_DATA]   = 1'b1;
		need[bsf_pkg::SLOT_CLOSE]  = item.frame_end;
		need[bsf_pkg::SLOT_TRAIL]  = item.frame_end;
	end

	assign pending = need & ~done_q;

	// lowest pending slot goes out first
	always_comb begin
		cur = bsf_pkg::SLOT_TRAIL;
		for (int i = NS - 1; i >= 0; i--) begin
			if (pending[i]) begin
				cur = bsf_pkg::slot_t'(3'(i));
			end
		end
	end

	assign cur_bit = NS'(1) << cur;
	assign is_last = (pending & ~cur_bit) == '0;

	assign out_free  = !out_v_q || out_ch.ready;
	assign fire      = item_valid && out_free;
	assign item_done = fire && is_last;

	always_comb begin
		seq_nx   = frame_seq_q;
		crc_base = crc_q;
		case (cur)
			bsf_pkg::SLOT_OPEN: begin
				byte_nx  = bsf_pkg::FLAG_BYTE;
				seq_nx   = item.seq_num[SeqW-1:0];
				crc_base = 8'h00;
			end
			bsf_pkg::SLOT_ESC:   byte_nx = bsf_pkg::ESC_BYTE;
			bsf_pkg::SLOT_DATA:  byte_nx = item.data_byte;
			bsf_pkg::SLOT_CLOSE: byte_nx = bsf_pkg::FLAG_BYTE;
			bsf_pkg::SLOT_TRAIL: byte_nx = crc_q;
			default:             byte_nx = item.data_byte;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q  <= 1'b0;
			crc_q       <= 8'h00;
			frame_seq_q <= '0;
			done_q      <= '0;
			out_v_q     <= 1'b0;
		end else begin
			if (fire) begin
				done_q      <= is_last ? '0 : (done_q | cur_bit);
				frame_seq_q <= seq_nx;
				if (cur == bsf_pkg::SLOT_OPEN) begin
					in_frame_q <= 1'b1;
				end
				if (cur == bsf_pkg::SLOT_TRAIL) begin
					in_frame_q <= 1'b0;
				end else begin
					crc_q <= bsf_pkg::crc8_update(crc_base, byte_nx, crc_poly);
				end
				out_v_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q   <= byte_nx;
			is_trailer_q <= (cur == bsf_pkg::SLOT_TRAIL);
			out_seq_q    <= 8'(seq_nx);
			run_last_q   <= is_last;
		end
	end

	assign out_ch.valid      = out_v_q;
	assign out_ch.out_byte   = out_byte_q;
	assign out_ch.is_trailer = is_trailer_q;
	assign out_ch.out_seq    = out_seq_q;
	assign out_ch.run_last   = run_last_q;

endmodule
`default_nettype wire

// File: sv/byte_stuff_framer_crc8.sv
// top level of the byte stuffing framer with crc-8 trailer
// usage:
//   in_ch carries one payload byte per transfer with frame_end on the last
//   byte and seq_num, which is sampled on the first byte of each frame.
//   out_ch gives the stuffed frame: opening '$', '/' escapes in front of
//   '$' and '/', the data, closing '$', then the crc byte with is_trailer
//   set. run_last marks the last output byte caused by one input transfer.
//   cfg_we/cfg_wdata write the crc polynomial; write it only while idle.
// timing:
//   an accepted byte sits in the input register until the sequencer has
//   sent each of the 1 to 5 output bytes it causes into the output
//   register, which takes one byte per cycle while out_ch.ready is high;
//   plain mid-frame bytes then go through at one per cycle.
// reset:
//   no frame open, crc cleared, polynomial back to 0x07.
// stall:
//   with out_ch.ready low the output register holds, the sequencer waits
//   and in_ch.ready drops once the input register is occupied.
`default_nettype none
module byte_stuff_framer_crc8 #(
	parameter int SEQ_BITS = bsf_pkg::SEQ_BITS_DEFAULT
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata,
	bsf_in_if.sink          in_ch,
	bsf_out_if.source       out_ch
);

	logic [7:0]     crc_poly_q;
	bsf_pkg::item_t item;
	logic           item_valid;
	logic           item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_poly_q <= bsf_pkg::CRC_POLY_RESET;
		end else if (cfg_we) begin
			crc_poly_q <= cfg_wdata;
		end
	end

	bsf_in_stage u_in_stage (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.item_done  (item_done),
		.item       (item),
		.item_valid (item_valid)
	);

	bsf_emit #(
		.SEQ_BITS (SEQ_BITS)
	) u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.crc_poly   (crc_poly_q),
		.item       (item),
		.item_valid (item_valid),
		.item_done  (item_done),
		.out_ch     (out_ch)
	);

endmodule
`default_nettype wire
